/* hw/rtl/sound_ram_transfer_port_core_assert.svh */
// ----------------------------------------------------------------------------
// Sound RAM transfer port: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOUND_RAM_TRANSFER_PORT_CORE_ASSERT_SVH
`define SOUND_RAM_TRANSFER_PORT_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SRTP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SRTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/srtp_pkg.sv */
// ----------------------------------------------------------------------------
// Sound RAM transfer port: package
// Opcodes, register indexes, sizes and the pointer control bundle.
// ----------------------------------------------------------------------------
package srtp_pkg;

	localparam int RAM_HALFWORDS = 262144;
	localparam int REG_HALFWORDS = 256;
	localparam int RAM_AW        = $clog2(RAM_HALFWORDS);
	localparam int REG_AW        = $clog2(REG_HALFWORDS);
	localparam int PTR_W         = 18;
	localparam int DATA_W        = 16;

	localparam logic [7:0] IDX_XFER_ADDR = 8'd211;
	localparam logic [7:0] IDX_DATA_PORT = 8'd212;

	typedef enum logic [1:0] {
		OP_REG_WRITE = 2'd0,
		OP_REG_READ  = 2'd1,
		OP_DMA_WRITE = 2'd2,
		OP_DMA_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic              load;
		logic              adv;
		logic [DATA_W-1:0] value;
	} ptr_ctl_t;

endpackage

/* hw/rtl/sound_ram_transfer_port_core.sv */
// ----------------------------------------------------------------------------
// Sound RAM transfer port core
// Register window with a 256-entry register file and a sound RAM data port
// with an auto-incrementing transfer pointer, shared with DMA halfwords.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in       | in_valid / in_ready  | opcode, reg_index, write_data
//  out      | out_valid / out_ready| read_data
//
//  One transaction per cycle sustained while the output is not stalled; each
//  result passes the access stage (the registered read of the sound RAM and
//  register file) and then the output register before it is presented.
//  Reset clears the pointer, the register-file valid bits and the pipeline;
//  unwritten register entries read as zero.
//  A stalled output holds the access stage, which then drops in_ready.
// ----------------------------------------------------------------------------
module sound_ram_transfer_port_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  opcode,
	input  logic [7:0]                  reg_index,
	input  logic [15:0]                 write_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [15:0]                 read_data
);

	import srtp_pkg::*;

	typedef enum logic [1:0] {
		SEL_IMM,
		SEL_REG,
		SEL_RAM
	} sel_t;

	op_t                  op;
	logic                 acc;
	logic                 adv;
	logic                 is_xfer;
	logic                 is_data;
	logic                 ram_we;
	logic                 ram_re;
	logic                 rf_we;
	logic                 rf_re;
	logic                 ptr_load;
	sel_t                 sel;
	logic [DATA_W-1:0]    imm;
	ptr_ctl_t             pctl;
	logic [RAM_AW-1:0]    slot;
	logic [DATA_W-1:0]    ptr_word;
	logic [DATA_W-1:0]    ram_rdata;
	logic [DATA_W-1:0]    rf_rdata;
	logic [DATA_W-1:0]    result;

	logic [REG_HALFWORDS-1:0] vld_q;
	logic                     v_s1;
	sel_t                     sel_s1;
	logic [DATA_W-1:0]        imm_s1;
	logic                     rvld_s1;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        read_data_q;

	assign op      = op_t'(opcode);
	assign is_xfer = (reg_index == IDX_XFER_ADDR);
	assign is_data = (reg_index == IDX_DATA_PORT);
	assign adv     = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign acc     = in_valid && in_ready;

	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		rf_we    = 1'b0;
		rf_re    = 1'b0;
		ptr_load = 1'b0;
		sel      = SEL_IMM;
		imm      = '0;
		unique case (op)
			OP_REG_WRITE: begin
				rf_we    = 1'b1;
				ptr_load = is_xfer;
				ram_we   = is_data;
			end
			OP_REG_READ: begin
				if (is_xfer) begin
					imm = ptr_word;
				end else if (is_data) begin
					ram_re = 1'b1;
					sel    = SEL_RAM;
				end else begin
					rf_re = 1'b1;
					sel   = SEL_REG;
				end
			end
			OP_DMA_WRITE: begin
				ram_we = 1'b1;
			end
			OP_DMA_READ: begin
				ram_re = 1'b1;
				sel    = SEL_RAM;
			end
			default: begin
				sel = SEL_IMM;
			end
		endcase
	end

	assign pctl.load  = acc && ptr_load;
	assign pctl.adv   = acc && (ram_we || ram_re);
	assign pctl.value = write_data;

	srtp_ptr u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pctl),
		.slot     (slot),
		.ptr_word (ptr_word)
	);

	srtp_ram #(
		.DEPTH (RAM_HALFWORDS),
		.WIDTH (DATA_W)
	) u_sram (
		.clk   (clk),
		.we    (acc && ram_we),
		.waddr (slot),
		.wdata (write_data),
		.re    (acc && ram_re),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	srtp_ram #(
		.DEPTH (REG_HALFWORDS),
		.WIDTH (DATA_W)
	) u_regs (
		.clk   (clk),
		.we    (acc && rf_we),
		.waddr (reg_index[REG_AW-1:0]),
		.wdata (write_data),
		.re    (acc && rf_re),
		.raddr (reg_index[REG_AW-1:0]),
		.rdata (rf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (acc && rf_we) begin
			vld_q[reg_index[REG_AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sel_s1  <= sel;
			imm_s1  <= imm;
			rvld_s1 <= vld_q[reg_index[REG_AW-1:0]];
		end
	end

	always_comb begin
		case (sel_s1)
			SEL_REG: result = rvld_s1 ? rf_rdata : '0;
			SEL_RAM: result = ram_rdata;
			default: result = imm_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

/* hw/rtl/srtp_ram.sv */
// ----------------------------------------------------------------------------
// Sound RAM transfer port: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srtp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/srtp_ptr.sv */
// ----------------------------------------------------------------------------
// Sound RAM transfer port: transfer pointer
// Halfword pointer with load, advance and wrap; supplies the RAM slot.
// ----------------------------------------------------------------------------
module srtp_ptr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  srtp_pkg::ptr_ctl_t               ctl,
	output logic [srtp_pkg::RAM_AW-1:0]      slot,
	output logic [srtp_pkg::DATA_W-1:0]      ptr_word
);

	import srtp_pkg::*;

	localparam logic [PTR_W:0] RAM_END = (PTR_W+1)'(RAM_HALFWORDS);
	localparam bit             POW2    = (RAM_HALFWORDS == (1 << RAM_AW));

	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] inc;

	assign inc      = ptr_q + PTR_W'(1);
	assign ptr_word = ptr_q[PTR_W-1:2];

	generate
		if (POW2) begin : g_mask
			assign slot = ptr_q[RAM_AW-1:0];
		end else begin : g_mod
			assign slot = RAM_AW'(ptr_q % PTR_W'(RAM_HALFWORDS));
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ctl.load) begin
			ptr_q <= {ctl.value, 2'b00};
		end else if (ctl.adv) begin
			ptr_q <= ({1'b0, inc} >= RAM_END) ? '0 : inc;
		end
	end

endmodule

/* hw/rtl/srtp_chk.sv */
// ----------------------------------------------------------------------------
// Sound RAM transfer port: port checker
// Watches the top-level ports for stall, latency and hold behavior.
// ----------------------------------------------------------------------------
`include "sound_ram_transfer_port_core_assert.svh"

module srtp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic [7:0]  reg_index,
	input logic [15:0] write_data,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] read_data
);

	logic        in_acc;
	logic        in_wait;
	logic        out_stall;
	logic [25:0] in_payload;

	assign in_acc     = in_valid && in_ready;
	assign in_wait    = in_valid && !in_ready;
	assign out_stall  = out_valid && !out_ready;
	assign in_payload = {opcode, reg_index, write_data};

	// input only stalls behind a full, stalled output
	`SRTP_ASSERT_NOW(a_in_stall, !in_ready, out_stall, "in_ready low, no stall")

	// a fresh result follows an accepted transaction through the access and output registers
	`SRTP_ASSERT_NOW(a_out_rise, $rose(out_valid), $past(in_acc, 2), "orphan result")

	// a stalled result holds its data
	`SRTP_ASSERT_NEXT(a_hold_data, out_stall, $stable(read_data), "read_data not held")

	// a waiting transaction stays offered with the same payload
	`SRTP_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_payload), "input not held")

endmodule

bind sound_ram_transfer_port_core srtp_chk u_chk (.*);
